// ===== design/ppt_pkg.sv =====
// Shared types and codes for the priority page table.
// Used by ppt_ctrl, ppt_dp and priority_page_table; depends on nothing.
package ppt_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_SET        = 3'd0;
   localparam logic [2:0] KIND_CLEAR_PAGE = 3'd1;
   localparam logic [2:0] KIND_CLEAR_ALL  = 3'd2;
   localparam logic [2:0] KIND_FIND       = 3'd3;
   localparam logic [2:0] KIND_REMOVE     = 3'd4;

   // Response status codes.
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_BAD_PRIORITY = 2'd1;
   localparam logic [1:0] STATUS_FULL         = 2'd2;

   // What the response register is loaded with.
   localparam logic [1:0] EMIT_STATUS = 2'd0;
   localparam logic [1:0] EMIT_FIND   = 2'd1;
   localparam logic [1:0] EMIT_HELD   = 2'd2;

   localparam int         KEY_PORT_BITS = 32;
   localparam logic [6:0] MOST_RESULTS  = 7'd64;

   typedef struct packed {
      logic       load;       // capture the request beat
      logic       clear;      // restart the address counter and scan trackers
      logic       sweep;      // write an empty entry at the counter and advance
      logic       scan;       // read the entry at the counter and advance
      logic       commit;     // apply the table update for the current kind
      logic       emit;       // load the response register
      logic [1:0] emit_sel;
      logic [1:0] emit_code;
      logic       emit_last;
   } ppt_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       prio_ok;
      logic       maxp_zero;
      logic       sweep_last;
      logic       scan_done;
      logic       hit;
      logic       free;
      logic       best;
      logic       have_held;
      logic       take_final;
      logic       slot_free;
   } ppt_stat_type;

endpackage

// ===== design/ppt_ctrl.sv =====
// Sequencer for the priority page table: steps each request through its scans,
// table updates and responses. Depends on ppt_pkg.
module ppt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ppt_pkg::ppt_stat_type stat,
   output ppt_pkg::ppt_cmd_type  cmd
);

   localparam logic [2:0] ST_INIT      = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_DISPATCH  = 3'd2;
   localparam logic [2:0] ST_SCAN      = 3'd3;
   localparam logic [2:0] ST_RESOLVE   = 3'd4;
   localparam logic [2:0] ST_TAKE_EMIT = 3'd5;
   localparam logic [2:0] ST_WIPE      = 3'd6;
   localparam logic [2:0] ST_REPLY     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sel_ff   <= ppt_pkg::EMIT_STATUS;
         code_ff  <= ppt_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            sel_in   = ppt_pkg::EMIT_STATUS;
            code_in  = ppt_pkg::STATUS_OK;
            state_in = ST_REPLY;
            case (stat.kind)
               ppt_pkg::KIND_SET: begin
                  if (!stat.prio_ok) begin
                     code_in = ppt_pkg::STATUS_BAD_PRIORITY;
                  end else begin
                     cmd.clear = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end
               ppt_pkg::KIND_CLEAR_PAGE, ppt_pkg::KIND_FIND: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_SCAN;
               end
               ppt_pkg::KIND_CLEAR_ALL: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_WIPE;
               end
               ppt_pkg::KIND_REMOVE: begin
                  if (!stat.prio_ok) begin
                     code_in = ppt_pkg::STATUS_BAD_PRIORITY;
                  end else if (!stat.maxp_zero) begin
                     cmd.clear = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            sel_in   = ppt_pkg::EMIT_STATUS;
            code_in  = ppt_pkg::STATUS_OK;
            state_in = ST_REPLY;
            case (stat.kind)
               ppt_pkg::KIND_SET: begin
                  if (stat.hit || stat.free) begin
                     cmd.commit = 1'b1;
                  end else begin
                     code_in = ppt_pkg::STATUS_FULL;
                  end
               end
               ppt_pkg::KIND_CLEAR_PAGE: begin
                  cmd.commit = stat.hit;
               end
               ppt_pkg::KIND_FIND: begin
                  sel_in = ppt_pkg::EMIT_FIND;
               end
               ppt_pkg::KIND_REMOVE: begin
                  // A taken page is held back until the page count or the next scan tells
                  // whether it is the final beat of the batch.
                  if (stat.best) begin
                     if (stat.have_held) begin
                        state_in = ST_TAKE_EMIT;
                     end else begin
                        cmd.commit = 1'b1;
                        if (stat.take_final) begin
                           sel_in = ppt_pkg::EMIT_HELD;
                        end else begin
                           cmd.clear = 1'b1;
                           state_in  = ST_SCAN;
                        end
                     end
                  end else if (stat.have_held) begin
                     sel_in = ppt_pkg::EMIT_HELD;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_TAKE_EMIT: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = ppt_pkg::EMIT_HELD;
               cmd.emit_code = ppt_pkg::STATUS_OK;
               cmd.emit_last = 1'b0;
               cmd.commit    = 1'b1;
               if (stat.take_final) begin
                  sel_in   = ppt_pkg::EMIT_HELD;
                  code_in  = ppt_pkg::STATUS_OK;
                  state_in = ST_REPLY;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_WIPE: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = sel_ff;
               cmd.emit_code = code_ff;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/ppt_dp.sv =====
// Datapath for the priority page table: entry memory, scan trackers, request
// and batch registers, and the response register. Depends on ppt_pkg.
module ppt_dp #(
   parameter int TABLE_ENTRIES   = 64,
   parameter int PRIORITY_LEVELS = 10,
   parameter int KEY_BITS        = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ppt_pkg::ppt_cmd_type                cmd,
   output ppt_pkg::ppt_stat_type               stat,
   input  logic [2:0]                          req_kind,
   input  logic [ppt_pkg::KEY_PORT_BITS-1:0]   req_page_key,
   input  logic [3:0]                          req_priority_req,
   input  logic [6:0]                          req_max_pages,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [3:0]                          rsp_found_priority,
   output logic [ppt_pkg::KEY_PORT_BITS-1:0]   rsp_out_key,
   output logic                                rsp_last
);

   localparam int KW = (KEY_BITS < ppt_pkg::KEY_PORT_BITS) ? KEY_BITS : ppt_pkg::KEY_PORT_BITS;
   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int MW = KW + 5;
   localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
   localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);

   // Each word is {valid, priority, key}.
   logic [MW-1:0] entry_mem [TABLE_ENTRIES];

   logic [2:0]    kind_ff;
   logic [KW-1:0] key_ff;
   logic [3:0]    prio_ff;
   logic [6:0]    maxp_ff;

   logic [CW-1:0] cnt_ff;
   logic          rd_vld_ff;
   logic [MW-1:0] rdata_ff;
   logic [IW-1:0] rd_idx_ff;

   logic          hit_ff, free_ff, best_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, best_idx_ff;
   logic [3:0]    hit_prio_ff;
   logic [KW-1:0] best_key_ff;
   logic [KW-1:0] held_key_ff;
   logic [6:0]    count_ff;

   logic                              rsp_valid_ff;
   logic [1:0]                        status_ff;
   logic                              found_ff;
   logic [3:0]                        fprio_ff;
   logic [ppt_pkg::KEY_PORT_BITS-1:0] okey_ff;
   logic                              last_ff;

   logic          issue;
   logic          we;
   logic [IW-1:0] waddr;
   logic [MW-1:0] wdata;
   logic          e_valid;
   logic [3:0]    e_prio;
   logic [KW-1:0] e_key;
   logic          hit_take, free_take, best_take;
   logic          take;

   assign issue = cmd.scan && (cnt_ff != CNT_END);
   assign take  = cmd.commit && (kind_ff == ppt_pkg::KIND_REMOVE);

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_page_key[KW-1:0];
         prio_ff <= req_priority_req;
         maxp_ff <= (req_max_pages > ppt_pkg::MOST_RESULTS) ? ppt_pkg::MOST_RESULTS
                                                            : req_max_pages;
      end
   end

   // Table write port: sweeps write empty entries, commits apply the update.
   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff[IW-1:0];
      wdata = '0;
      if (cmd.sweep) begin
         we = 1'b1;
      end else if (cmd.commit) begin
         case (kind_ff)
            ppt_pkg::KIND_SET: begin
               we    = 1'b1;
               waddr = hit_ff ? hit_idx_ff : free_idx_ff;
               wdata = {1'b1, prio_ff, key_ff};
            end
            ppt_pkg::KIND_CLEAR_PAGE: begin
               we    = 1'b1;
               waddr = hit_idx_ff;
            end
            ppt_pkg::KIND_REMOVE: begin
               we    = 1'b1;
               waddr = best_idx_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         entry_mem[waddr] <= wdata;
      end
      if (issue) begin
         rdata_ff  <= entry_mem[cnt_ff[IW-1:0]];
         rd_idx_ff <= cnt_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.clear) begin
            cnt_ff <= '0;
         end else if (cmd.sweep || issue) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   // Scan trackers work on the registered read data, one entry per cycle.
   assign e_valid = rdata_ff[MW-1];
   assign e_prio  = rdata_ff[MW-2 -: 4];
   assign e_key   = rdata_ff[KW-1:0];

   assign hit_take  = rd_vld_ff && e_valid && (e_key == key_ff) && !hit_ff;
   assign free_take = rd_vld_ff && !e_valid && !free_ff;
   assign best_take = rd_vld_ff && e_valid && (e_prio == prio_ff) &&
                      (!best_ff || (e_key < best_key_ff));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         best_ff <= 1'b0;
      end else begin
         if (hit_take) begin
            hit_ff <= 1'b1;
         end
         if (free_take) begin
            free_ff <= 1'b1;
         end
         if (best_take) begin
            best_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit_take) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_prio_ff <= e_prio;
      end
      if (free_take) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (best_take) begin
         best_idx_ff <= rd_idx_ff;
         best_key_ff <= e_key;
      end
      if (take) begin
         held_key_ff <= best_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         count_ff <= '0;
      end else if (take) begin
         count_ff <= count_ff + 7'd1;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         last_ff <= cmd.emit_last;
         case (cmd.emit_sel)
            ppt_pkg::EMIT_FIND: begin
               status_ff <= ppt_pkg::STATUS_OK;
               found_ff  <= hit_ff;
               fprio_ff  <= hit_ff ? hit_prio_ff : 4'd0;
               okey_ff   <= '0;
            end
            ppt_pkg::EMIT_HELD: begin
               status_ff <= ppt_pkg::STATUS_OK;
               found_ff  <= 1'b1;
               fprio_ff  <= prio_ff;
               okey_ff   <= ppt_pkg::KEY_PORT_BITS'(held_key_ff);
            end
            default: begin
               status_ff <= cmd.emit_code;
               found_ff  <= 1'b0;
               fprio_ff  <= 4'd0;
               okey_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_priority = fprio_ff;
   assign rsp_out_key        = okey_ff;
   assign rsp_last           = last_ff;

   always_comb begin
      stat            = '0;
      stat.kind       = kind_ff;
      stat.prio_ok    = (prio_ff != 4'd0) && (prio_ff <= 4'(PRIORITY_LEVELS));
      stat.maxp_zero  = (maxp_ff == 7'd0);
      stat.sweep_last = (cnt_ff == CNT_LAST);
      stat.scan_done  = (cnt_ff == CNT_END) && !rd_vld_ff;
      stat.hit        = hit_ff;
      stat.free       = free_ff;
      stat.best       = best_ff;
      stat.have_held  = (count_ff != 7'd0);
      stat.take_final = ((count_ff + 7'd1) == maxp_ff);
      stat.slot_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== design/priority_page_table.sv =====
// Top level of the priority page table: joins the sequencer and the datapath.
// Depends on ppt_pkg, ppt_ctrl and ppt_dp.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   kind, page_key, priority_req, max_pages
//   rsp_      out         rsp_valid/rsp_stall   status, found, found_priority, out_key, last
//
// A lookup request scans the whole table: every lookup reads the entry memory one entry per
// cycle through its single read port. A remove batch rescans the table after each page it
// takes, unless that page fills max_pages. Clear all sweeps the whole memory; after reset
// the same sweep runs with req_stall high. One request is in work at a time; the response
// register lets the next request beat in while a response is stalled.
module priority_page_table #(
   parameter int TABLE_ENTRIES   = 64,
   parameter int PRIORITY_LEVELS = 10,
   parameter int KEY_BITS        = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_kind,
   input  logic [ppt_pkg::KEY_PORT_BITS-1:0] req_page_key,
   input  logic [3:0]                        req_priority_req,
   input  logic [6:0]                        req_max_pages,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_found,
   output logic [3:0]                        rsp_found_priority,
   output logic [ppt_pkg::KEY_PORT_BITS-1:0] rsp_out_key,
   output logic                              rsp_last
);

   ppt_pkg::ppt_cmd_type  cmd;
   ppt_pkg::ppt_stat_type stat;

   ppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppt_dp #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .KEY_BITS        (KEY_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_page_key       (req_page_key),
      .req_priority_req   (req_priority_req),
      .req_max_pages      (req_max_pages),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_found_priority (rsp_found_priority),
      .rsp_out_key        (rsp_out_key),
      .rsp_last           (rsp_last)
   );

endmodule
